/* src/ookd_pkg.sv */
// ----------------------------------------------------------------------------
// ookd_pkg
// Shared types and constants for the on-off keying energy demodulator.
// ----------------------------------------------------------------------------
package ookd_pkg;

    // default sizing
    localparam int BITS_PER_BYTE_DEF = 8;
    localparam int SAMPLE_BITS_DEF   = 12;

    // register field widths
    localparam int LEVEL_W    = 12;
    localparam int SUM_W      = 18;
    localparam int SPB_W      = 6;
    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 2;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // register reset values
    localparam logic [LEVEL_W-1:0] START_LEVEL_RST     = 12'd100;
    localparam logic [SUM_W-1:0]   ENERGY_LEVEL_RST    = 18'd4000;
    localparam logic [LEVEL_W-1:0] GAP_LEVEL_RST       = 12'd3000;
    localparam logic [SPB_W-1:0]   SAMPLES_PER_BIT_RST = 6'd11;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_LEVEL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LEVEL       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_BIT = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_RECV = 3'b010,
        PH_GAP  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] start_level;
        logic [SUM_W-1:0]   energy_level;
        logic [LEVEL_W-1:0] gap_level;
        logic [SPB_W-1:0]   samples_per_bit;
    } cfg_t;

    typedef struct packed {
        logic              byte_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              receiving;
    } result_t;

endpackage

/* src/ookd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ookd_cfg_regs
// Configuration register file: thresholds and bit period length.
// ----------------------------------------------------------------------------
module ookd_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ookd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ookd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ookd_pkg::cfg_t                   cfg
);
    import ookd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_LEVEL:     cfg_next.start_level     = cfg_data[LEVEL_W-1:0];
                CFG_ENERGY_LEVEL:    cfg_next.energy_level    = cfg_data[SUM_W-1:0];
                CFG_GAP_LEVEL:       cfg_next.gap_level       = cfg_data[LEVEL_W-1:0];
                CFG_SAMPLES_PER_BIT: cfg_next.samples_per_bit = cfg_data[SPB_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_level     <= START_LEVEL_RST;
            cfg_reg.energy_level    <= ENERGY_LEVEL_RST;
            cfg_reg.gap_level       <= GAP_LEVEL_RST;
            cfg_reg.samples_per_bit <= SAMPLES_PER_BIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/ookd_core.sv */
// ----------------------------------------------------------------------------
// ookd_core
// Per-sample receiver state update: start detect, difference energy
// accumulation, bit decision, byte assembly and inter-byte gap wait.
// ----------------------------------------------------------------------------
module ookd_core #(
    parameter int BITS_PER_BYTE = ookd_pkg::BITS_PER_BYTE_DEF,
    parameter int SAMPLE_BITS   = ookd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  ookd_pkg::cfg_t         cfg,
    output ookd_pkg::result_t      result
);
    import ookd_pkg::*;

    localparam int BC_W  = (BITS_PER_BYTE > 1) ? $clog2(BITS_PER_BYTE) : 1;
    localparam int CMP_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
    localparam logic [BC_W:0] BPB = (BC_W+1)'(BITS_PER_BYTE);

    phase_t                 phase_reg,    phase_next;
    logic [SAMPLE_BITS-1:0] prev_reg,     prev_next;
    logic [SUM_W-1:0]       sum_reg,      sum_next;
    logic [SPB_W-1:0]       scnt_reg,     scnt_next;
    logic [BC_W-1:0]        bcnt_reg,     bcnt_next;
    logic [BYTE_W-1:0]      shift_reg,    shift_next;
    logic                   gap_seen_reg, gap_seen_next;

    logic [SAMPLE_BITS-1:0] diff;
    logic [SUM_W:0]         sum_wide;
    logic [SUM_W-1:0]       sum_sat;
    logic [SPB_W-1:0]       scnt_inc;
    logic [BC_W:0]          nbits;
    logic                   bit_one;
    logic [BYTE_W-1:0]      shifted;
    logic                   above_start;
    logic                   above_gap;

    assign diff     = (sample >= prev_reg) ? (sample - prev_reg) : (prev_reg - sample);
    assign sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(diff);
    assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign scnt_inc = scnt_reg + 1'b1;
    assign nbits    = {1'b0, bcnt_reg} + 1'b1;
    assign bit_one  = sum_sat > cfg.energy_level;
    assign shifted  = {shift_reg[BYTE_W-2:0], bit_one};

    assign above_start = CMP_W'(sample) > CMP_W'(cfg.start_level);
    assign above_gap   = CMP_W'(sample) > CMP_W'(cfg.gap_level);

    always_comb
    begin
        phase_next    = phase_reg;
        prev_next     = prev_reg;
        sum_next      = sum_reg;
        scnt_next     = scnt_reg;
        bcnt_next     = bcnt_reg;
        shift_next    = shift_reg;
        gap_seen_next = gap_seen_reg;
        result.byte_valid = 1'b0;
        result.rx_byte    = '0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (above_start)
                begin
                    // first sample only seeds the difference chain
                    phase_next = PH_RECV;
                    scnt_next  = '0;
                    bcnt_next  = '0;
                    shift_next = '0;
                    prev_next  = sample;
                    sum_next   = '0;
                end
            end
            PH_RECV:
            begin
                prev_next = sample;
                sum_next  = sum_sat;
                scnt_next = scnt_inc;
                if (scnt_inc >= cfg.samples_per_bit)
                begin
                    scnt_next  = '0;
                    sum_next   = '0;
                    shift_next = shifted;
                    if (nbits >= BPB)
                    begin
                        result.byte_valid = 1'b1;
                        result.rx_byte    = shifted;
                        shift_next        = '0;
                        bcnt_next         = '0;
                        gap_seen_next     = 1'b0;
                        phase_next        = PH_GAP;
                    end
                    else
                    begin
                        bcnt_next = nbits[BC_W-1:0];
                    end
                end
            end
            default:
            begin
                // gap wait: tone above gap level, then a quiet sample rearms
                if (above_gap)
                begin
                    gap_seen_next = 1'b1;
                end
                else if (gap_seen_reg)
                begin
                    gap_seen_next = 1'b0;
                    phase_next    = PH_IDLE;
                end
            end
        endcase

        result.receiving = (phase_next == PH_RECV);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            prev_reg     <= '0;
            sum_reg      <= '0;
            scnt_reg     <= '0;
            bcnt_reg     <= '0;
            shift_reg    <= '0;
            gap_seen_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            prev_reg     <= prev_next;
            sum_reg      <= sum_next;
            scnt_reg     <= scnt_next;
            bcnt_reg     <= bcnt_next;
            shift_reg    <= shift_next;
            gap_seen_reg <= gap_seen_next;
        end
    end

endmodule

/* src/ook_energy_demodulator.sv */
// ----------------------------------------------------------------------------
// ook_energy_demodulator
// On-off keying demodulator: one result beat per ADC sample beat.
// ----------------------------------------------------------------------------
// Path: an accepted sample is held in the input register, then its state
//   update is registered into the result register, raising result valid.
// Throughput: one sample per cycle while result_ready is high; the update
//   is one subtract, saturating add and compare between the two registers.
// Reset: all receiver state cleared, registers at defaults, channels empty.
// ----------------------------------------------------------------------------
module ook_energy_demodulator #(
    parameter int BITS_PER_BYTE = ookd_pkg::BITS_PER_BYTE_DEF,
    parameter int SAMPLE_BITS   = ookd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ookd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ookd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             sample_valid,
    output logic                             sample_ready,
    input  logic [SAMPLE_BITS-1:0]           adc_sample,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic                             byte_valid,
    output logic [ookd_pkg::BYTE_W-1:0]      rx_byte,
    output logic                             receiving
);
    import ookd_pkg::*;

    cfg_t                   cfg;
    result_t                core_result;
    result_t                res_reg;
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic                   res_valid_reg;
    logic                   advance;

    // move the held sample on whenever the result register is free or draining
    assign advance      = in_valid_reg && (!res_valid_reg || result_ready);
    assign sample_ready = !in_valid_reg || advance;

    ookd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ookd_core #(
        .BITS_PER_BYTE (BITS_PER_BYTE),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .sample  (in_sample_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_ready)
            begin
                in_valid_reg <= sample_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid)
        begin
            in_sample_reg <= adc_sample;
        end
        if (advance)
        begin
            res_reg <= core_result;
        end
    end

    assign result_valid = res_valid_reg;
    assign byte_valid   = res_reg.byte_valid;
    assign rx_byte      = res_reg.rx_byte;
    assign receiving    = res_reg.receiving;

endmodule

/* src/ookd_checker.sv */
// ----------------------------------------------------------------------------
// ookd_checker
// Port-level checks for the demodulator, bound to the top level.
// ----------------------------------------------------------------------------
module ookd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       sample_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic       byte_valid,
    input logic [7:0] rx_byte,
    input logic       receiving
);

    // hold a stalled result beat
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(rx_byte)
            && $stable(byte_valid) && $stable(receiving))
        else $error("stalled result beat changed");

    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> sample_ready)
        else $error("input stalled with empty result register");

    // a byte beat drops the receiver into gap wait
    a_byte_ends_recv: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && byte_valid |-> !receiving)
        else $error("still receiving after byte delivered");

    // byte payload is zero unless a byte is delivered
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !byte_valid |-> rx_byte == 8'd0)
        else $error("nonzero byte without byte_valid");

endmodule

bind ook_energy_demodulator ookd_checker u_ookd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .byte_valid   (byte_valid),
    .rx_byte      (rx_byte),
    .receiving    (receiving)
);
